// ----- hw/rtl/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the serial packet deframer: operation codes,
// configuration register indexes, buffer geometry and inter-module structs.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Payload buffer geometry (one ping-pong half)
    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = 9;                      // holds 0..256
    localparam int HWM_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int RAM_DEPTH    = 2 * BUFFER_DEPTH;

    // Header byte defaults
    localparam logic [7:0] FIRST_HEADER_RESET  = 8'd84;
    localparam logic [7:0] SECOND_HEADER_RESET = 8'd254;

    // Operation codes
    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ACK     = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] CFG_FIRST_HEADER  = 8'd0;
    localparam logic [7:0] CFG_SECOND_HEADER = 8'd1;

    // Buffer write request from the parser
    typedef struct packed {
        logic              en;
        logic              bank;   // 0: buffer A, 1: buffer B
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } spd_wr_t;

    // Parser status after one step
    typedef struct packed {
        logic       frame_done;
        logic       checksum_ok;
        logic       frame_ready;
        logic [7:0] packet_type;
        logic [7:0] frame_length;
        logic [2:0] parser_phase;
    } spd_status_t;

endpackage

// ----- hw/rtl/spd_ram.sv -----
// ----------------------------------------------------------------------------
// spd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/spd_parser.sv -----
// ----------------------------------------------------------------------------
// spd_parser
// Frame state machine: header hunt, type and length capture, payload sum,
// checksum check, ready flag and ping-pong buffer selection.
// ----------------------------------------------------------------------------
module spd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          op,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          first_header,
    input  logic [7:0]          second_header,
    output spd_pkg::spd_wr_t     wr,
    output spd_pkg::spd_status_t status_next,
    output logic                fill_select
);
    import spd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_TYPE = 3'd2,
        PH_LEN  = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [7:0] type_reg,   type_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg,  count_next;
    logic [7:0] sum_reg,    sum_next;
    logic       fill_reg,   fill_next;
    logic       ready_reg,  ready_next;
    logic       done;
    logic       ok;

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        fill_next   = fill_reg;
        ready_next  = ready_reg;
        done        = 1'b0;
        ok          = 1'b0;
        wr.en       = 1'b0;
        wr.bank     = ~fill_reg;
        wr.addr     = count_reg[ADDR_W-1:0];
        wr.data     = rx_byte;

        case (op)
            OP_RX_BYTE:
            begin
                unique case (phase_reg)
                    PH_HDR1:
                    begin
                        if (rx_byte == first_header)
                        begin
                            phase_next = PH_HDR2;
                        end
                    end
                    PH_HDR2:
                    begin
                        if (rx_byte == second_header)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        sum_next   = 8'd0;
                        type_next  = rx_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        length_next = rx_byte;
                        count_next  = 8'd0;
                        phase_next  = (rx_byte == 8'd0) ? PH_HDR1 : PH_PAY;
                    end
                    PH_PAY:
                    begin
                        if (({1'b0, count_reg} + 9'd1) == {1'b0, length_reg})
                        begin
                            // closing checksum byte
                            done       = 1'b1;
                            if (sum_reg == rx_byte)
                            begin
                                ok         = 1'b1;
                                ready_next = 1'b1;
                            end
                            fill_next  = ~fill_reg;
                            phase_next = PH_HDR1;
                        end
                        else
                        begin
                            // drop the store past depth, keep summing
                            wr.en      = ({1'b0, count_reg} < CNT_W'(BUFFER_DEPTH));
                            sum_next   = sum_reg + rx_byte;
                            count_next = count_reg + 8'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HDR1;
                    end
                endcase
            end
            OP_ACK:
            begin
                ready_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            type_reg   <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            fill_reg   <= 1'b0;
            ready_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            ready_reg  <= ready_next;
        end
    end

    always_comb
    begin
        status_next.frame_done   = done;
        status_next.checksum_ok  = ok;
        status_next.frame_ready  = ready_next;
        status_next.packet_type  = type_next;
        status_next.frame_length = length_next;
        status_next.parser_phase = phase_next;
    end

    assign fill_select = fill_reg;

endmodule

// ----- hw/rtl/serial_packet_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// serial_packet_deframer_unit
// Serial packet deframer with an 8-bit additive checksum and ping-pong
// payload buffers.
// ----------------------------------------------------------------------------
// Result path: RAM read stage, then result register; out_valid rises when an
//   accepted item moves on from the RAM read stage into the result register.
// Throughput: one item per cycle while the result channel is not stalled; set by
//   the one write port plus one read port of the shared buffer RAM.
// Reset (rst_n, async, active low): parser state, handshake valids and
//   fill marks clear at once; no clearing pass, so items are taken right away.
// ----------------------------------------------------------------------------
module serial_packet_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    // input item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    input  logic [7:0] read_index,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_done,
    output logic       checksum_ok,
    output logic       frame_ready,
    output logic [7:0] packet_type,
    output logic [7:0] frame_length,
    output logic [7:0] read_data,
    output logic [2:0] parser_phase,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import spd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration: header registers, always ready
    // ------------------------------------------------------------------
    logic [7:0] hdr1_reg;
    logic [7:0] hdr2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg <= FIRST_HEADER_RESET;
            hdr2_reg <= SECOND_HEADER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIRST_HEADER:  hdr1_reg <= cfg_data;
                CFG_SECOND_HEADER: hdr2_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: stage 1 (RAM read data) and stage 2 (result register).
    // Stage 1 advances whenever the result register is empty or drained,
    // so the input stalls only while both stages hold an item and the
    // result is stalled.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic accept;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Frame parser
    // ------------------------------------------------------------------
    spd_wr_t     wr;
    spd_status_t status_next;
    logic        fill_select;

    spd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (op),
        .rx_byte       (rx_byte),
        .first_header  (hdr1_reg),
        .second_header (hdr2_reg),
        .wr            (wr),
        .status_next   (status_next),
        .fill_select   (fill_select)
    );

    // ------------------------------------------------------------------
    // Fill marks: each frame fills its buffer from position 0 upward, so an
    // entry has ever been written exactly when it lies below the buffer's
    // high-water mark. Entries at or above the mark read as zero, which matches
    // the cleared buffers after reset.
    // ------------------------------------------------------------------
    logic [HWM_W-1:0] hwm_a_reg;
    logic [HWM_W-1:0] hwm_b_reg;
    logic             wr_fresh;

    assign wr_fresh = (CNT_W'(wr.addr) == CNT_W'(wr.bank ? hwm_b_reg : hwm_a_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hwm_a_reg <= '0;
            hwm_b_reg <= '0;
        end
        else if (accept && wr.en && wr_fresh)
        begin
            if (wr.bank)
            begin
                hwm_b_reg <= hwm_b_reg + HWM_W'(1);
            end
            else
            begin
                hwm_a_reg <= hwm_a_reg + HWM_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Buffer RAM: bank 0 is buffer A, bank 1 is buffer B. Reads go to the
    // completed buffer, writes to the one being filled, so the two ports
    // never touch the same half in one cycle.
    // ------------------------------------------------------------------
    logic                  rd_bank;
    logic                  rd_hit;
    logic [HWM_W-1:0]      rd_hwm;
    logic [7:0]            ram_rd_data;

    assign rd_bank = fill_select;
    assign rd_hwm  = rd_bank ? hwm_b_reg : hwm_a_reg;
    assign rd_hit  = (op == OP_READ) && ({1'b0, read_index} < CNT_W'(rd_hwm));

    spd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && wr.en),
        .wr_addr ({wr.bank, wr.addr}),
        .wr_data (wr.data),
        .rd_en   (accept),
        .rd_addr ({rd_bank, read_index[ADDR_W-1:0]}),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: hold the post-step status beside the RAM read
    // ------------------------------------------------------------------
    spd_status_t s1_status_reg;
    logic        s1_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_next;
            s1_hit_reg    <= rd_hit;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result register; a miss reads as zero
    // ------------------------------------------------------------------
    spd_status_t out_status_reg;
    logic [7:0]  out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_data_reg   <= s1_hit_reg ? ram_rd_data : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_done   = out_status_reg.frame_done;
    assign checksum_ok  = out_status_reg.checksum_ok;
    assign frame_ready  = out_status_reg.frame_ready;
    assign packet_type  = out_status_reg.packet_type;
    assign frame_length = out_status_reg.frame_length;
    assign parser_phase = out_status_reg.parser_phase;
    assign read_data    = out_data_reg;

endmodule

// ----- verif/spd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_tb_pkg
// Status prediction and checking for the serial packet deframer testbench:
// parser phase codes, the per-transfer status struct and a small scoreboard.
// ----------------------------------------------------------------------------
package spd_tb_pkg;

    import spd_pkg::*;

    localparam logic [2:0] PH_FIRST_HDR  = 3'd0;
    localparam logic [2:0] PH_SECOND_HDR = 3'd1;
    localparam logic [2:0] PH_TYPE       = 3'd2;
    localparam logic [2:0] PH_LENGTH     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD    = 3'd4;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic       frame_done;
        logic       checksum_ok;
        logic       frame_ready;
        logic [7:0] packet_type;
        logic [7:0] frame_length;
        logic [7:0] read_data;
        logic [2:0] parser_phase;
    } deframer_status_t;

    class deframer_scoreboard;

        logic [7:0] hdr_first;
        logic [7:0] hdr_second;
        logic [2:0] phase;
        logic [7:0] type_q;
        logic [7:0] length_q;
        logic [7:0] count_q;
        logic [7:0] sum_q;
        logic       fill_sel;      // 0: filling bank B, bank A is complete
        logic       ready_q;
        logic [7:0] bank_a [BUFFER_DEPTH];
        logic [7:0] bank_b [BUFFER_DEPTH];

        deframer_status_t status_due[$];
        int failures;

        function new();
            hdr_first  = FIRST_HEADER_RESET;
            hdr_second = SECOND_HEADER_RESET;
            phase      = PH_FIRST_HDR;
            type_q     = '0;
            length_q   = '0;
            count_q    = '0;
            sum_q      = '0;
            fill_sel   = 1'b0;
            ready_q    = 1'b0;
            failures   = 0;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                bank_a[i] = '0;
                bank_b[i] = '0;
            end
        endfunction

        function void write_register(logic [7:0] reg_index, logic [7:0] data);
            case (reg_index)
                CFG_FIRST_HEADER:  hdr_first  = data;
                CFG_SECOND_HEADER: hdr_second = data;
                default: ;
            endcase
        endfunction

        // Advance the header hunt and payload accumulation by one byte.
        function void take_byte(logic [7:0] b, output logic done, output logic ok);
            done = 1'b0;
            ok   = 1'b0;
            case (phase)
                PH_FIRST_HDR:
                    if (b == hdr_first)
                        phase = PH_SECOND_HDR;
                PH_SECOND_HDR:
                    if (b == hdr_second)
                        phase = PH_TYPE;
                PH_TYPE:
                begin
                    sum_q  = '0;
                    type_q = b;
                    phase  = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    length_q = b;
                    count_q  = '0;
                    phase    = (b == 8'd0) ? PH_FIRST_HDR : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                    if ({1'b0, count_q} + 9'd1 == {1'b0, length_q})
                    begin
                        done = 1'b1;
                        if (sum_q == b)
                        begin
                            ok      = 1'b1;
                            ready_q = 1'b1;
                        end
                        fill_sel = ~fill_sel;
                        phase    = PH_FIRST_HDR;
                    end
                    else
                    begin
                        if (count_q < BUFFER_DEPTH)
                        begin
                            if (fill_sel)
                                bank_a[count_q] = b;
                            else
                                bank_b[count_q] = b;
                        end
                        sum_q   = sum_q + b;
                        count_q = count_q + 8'd1;
                    end
                default:
                    phase = PH_FIRST_HDR;
            endcase
        endfunction

        // Predict the status of one accepted input transfer and queue it.
        function void note_transfer(logic [1:0] op, logic [7:0] rx, logic [7:0] pos);
            deframer_status_t want;
            logic done;
            logic ok;
            want = '0;
            done = 1'b0;
            ok   = 1'b0;
            case (op)
                OP_RX_BYTE: take_byte(rx, done, ok);
                OP_READ:
                    if (pos < BUFFER_DEPTH)
                        want.read_data = fill_sel ? bank_b[pos] : bank_a[pos];
                OP_ACK:     ready_q = 1'b0;
                default: ;
            endcase
            want.frame_done   = done;
            want.checksum_ok  = ok;
            want.frame_ready  = ready_q;
            want.packet_type  = type_q;
            want.frame_length = length_q;
            want.parser_phase = phase;
            status_due.push_back(want);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_status(deframer_status_t got);
            deframer_status_t want;
            if (status_due.size() == 0)
            begin
                flag("status transfer with nothing expected");
                return;
            end
            want = status_due.pop_front();
            if (got.frame_done   !== want.frame_done   ||
                got.checksum_ok  !== want.checksum_ok  ||
                got.frame_ready  !== want.frame_ready  ||
                got.packet_type  !== want.packet_type  ||
                got.frame_length !== want.frame_length ||
                got.read_data    !== want.read_data    ||
                got.parser_phase !== want.parser_phase)
                flag($sformatf({"done/ok/ready/type/len/rd/phase expected ",
                                "%b/%b/%b/%h/%h/%h/%0d got %b/%b/%b/%h/%h/%h/%0d"},
                               want.frame_done, want.checksum_ok, want.frame_ready,
                               want.packet_type, want.frame_length, want.read_data,
                               want.parser_phase, got.frame_done, got.checksum_ok,
                               got.frame_ready, got.packet_type, got.frame_length,
                               got.read_data, got.parser_phase));
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function void close_out();
            if (status_due.size() != 0)
                flag($sformatf("%0d expected status transfers never arrived",
                               status_due.size()));
        endfunction

    endclass

endpackage

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives framed and unframed serial bytes, payload reads, acknowledges and
// header register changes into the deframer, predicts every status transfer
// and compares it field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;
    import spd_tb_pkg::*;

    localparam int STALL_LIMIT  = 4000;   // cycles with no transfer at all
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 6;
    localparam int IDLE_PERCENT = 25;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic       out_valid;
    logic       out_stall;
    logic       frame_done;
    logic       checksum_ok;
    logic       frame_ready;
    logic [7:0] packet_type;
    logic [7:0] frame_length;
    logic [7:0] read_data;
    logic [2:0] parser_phase;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    deframer_scoreboard sb = new();
    deframer_status_t   seen_status;

    // Header values currently programmed, used to build well-formed frames
    logic [7:0] hdr_first_now  = FIRST_HEADER_RESET;
    logic [7:0] hdr_second_now = SECOND_HEADER_RESET;

    bit calm = 1'b0;          // set: no idling on either side
    int items_sent = 0;
    int quiet_cycles = 0;

    serial_packet_deframer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_done   (frame_done),
        .checksum_ok  (checksum_ok),
        .frame_ready  (frame_ready),
        .packet_type  (packet_type),
        .frame_length (frame_length),
        .read_data    (read_data),
        .parser_phase (parser_phase),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Stall the result channel at random; hold it open during the calm stretch.
    always @(negedge clk)
        out_stall = !calm && ($urandom_range(99) < IDLE_PERCENT);

    // Sample both channels at the rising edge: note accepted inputs, check results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_transfer(op, rx_byte, read_index);
            if (out_valid && !out_stall)
            begin
                seen_status.frame_done   = frame_done;
                seen_status.checksum_ok  = checksum_ok;
                seen_status.frame_ready  = frame_ready;
                seen_status.packet_type  = packet_type;
                seen_status.frame_length = frame_length;
                seen_status.read_data    = read_data;
                seen_status.parser_phase = parser_phase;
                sb.check_status(seen_status);
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("testbench: FAIL");
                    $finish;
                end
            end
        end
    end

    // Present one input item and hold it until the transfer happens.
    // Random idle cycles go in front of the item; the item stays on the port
    // after its transfer, so callers that stop sending must drop valid.
    task automatic send_item(input logic [1:0] code, input logic [7:0] rx_value,
                             input logic [7:0] pos, input bit counts = 1'b1);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        op         = code;
        rx_byte    = rx_value;
        read_index = pos;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (counts)
            items_sent++;
    endtask

    // Drop valid and wait until every predicted status transfer has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] reg_index, input logic [7:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = reg_index;
        cfg_data  = data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_register(reg_index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send a complete frame with random type and payload. Length counts the
    // closing checksum byte; length zero abandons the frame after the length.
    task automatic send_frame(input int len, input bit spoil);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        send_item(OP_RX_BYTE, hdr_first_now, 8'($urandom_range(255)));
        send_item(OP_RX_BYTE, hdr_second_now, 8'($urandom_range(255)));
        send_item(OP_RX_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
        send_item(OP_RX_BYTE, len[7:0], 8'($urandom_range(255)));
        for (int k = 1; k < len; k++)
        begin
            b   = 8'($urandom_range(255));
            sum = sum + b;
            send_item(OP_RX_BYTE, b, 8'($urandom_range(255)));
        end
        if (len != 0)
            send_item(OP_RX_BYTE, spoil ? sum + 8'($urandom_range(1, 255)) : sum,
                      8'($urandom_range(255)));
    endtask

    // Mostly well-formed frames with random content; the rest is noise,
    // broken headers, abandoned frames, reads, acknowledges and unused ops.
    task automatic run_random(input int quota);
        int pick;
        int n;
        logic [7:0] b;
        while (items_sent < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                if ($urandom_range(99) < 4)
                    send_frame($urandom_range(64, 255), $urandom_range(99) < 20);
                else
                    send_frame($urandom_range(1, 16), $urandom_range(99) < 20);
            end
            else if (pick < 70)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(OP_RX_BYTE, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'b0);
            end
            else if (pick < 73)
            begin
                // first header followed by a wrong second header
                b = 8'($urandom_range(255));
                if (b == hdr_second_now)
                    b = b ^ 8'h01;
                send_item(OP_RX_BYTE, hdr_first_now, 8'($urandom_range(255)));
                send_item(OP_RX_BYTE, b, 8'($urandom_range(255)));
            end
            else if (pick < 76)
                send_frame(0, 1'b0);
            else if (pick < 88)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_item(OP_READ, 8'($urandom_range(255)),
                              ($urandom_range(99) < 60) ? 8'($urandom_range(15))
                                                        : 8'($urandom_range(255)));
            end
            else if (pick < 95)
                send_item(OP_ACK, 8'($urandom_range(255)), 8'($urandom_range(255)));
            else
                send_item(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic [7:0] hf;
        logic [7:0] hs;
        int         quota;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_RX_BYTE;
        rx_byte    = '0;
        read_index = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_FIRST_HEADER;
        cfg_data   = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset header values.
        // Ignore a non-header byte while hunting.
        send_item(OP_RX_BYTE, 8'h00, 8'hFF);
        // Hold phase on a wrong second header, then continue the hunt.
        send_item(OP_RX_BYTE, FIRST_HEADER_RESET, 8'h00);
        send_item(OP_RX_BYTE, 8'h55, 8'h00);
        send_item(OP_RX_BYTE, SECOND_HEADER_RESET, 8'h00);
        // Abandon on length zero: no swap, no frame_done.
        send_item(OP_RX_BYTE, 8'hFF, 8'h00);
        send_item(OP_RX_BYTE, 8'h00, 8'h00);
        // Good frame, payload FF 01 wraps the sum to zero.
        send_item(OP_RX_BYTE, FIRST_HEADER_RESET, 8'h00);
        send_item(OP_RX_BYTE, SECOND_HEADER_RESET, 8'h00);
        send_item(OP_RX_BYTE, 8'h00, 8'h00);
        send_item(OP_RX_BYTE, 8'h03, 8'h00);
        send_item(OP_RX_BYTE, 8'hFF, 8'h00);
        send_item(OP_RX_BYTE, 8'h01, 8'h00);
        send_item(OP_RX_BYTE, 8'h00, 8'h00);
        // Read from the completed buffer at both ends of the index range.
        send_item(OP_READ, 8'h00, 8'h00);
        send_item(OP_READ, 8'hFF, 8'hFF);
        send_item(OP_READ, 8'h00, 8'h01);
        send_item(OP_ACK, 8'hFF, 8'hFF);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
        // Checksum-only frame with a bad closing byte: ready flag is kept.
        send_item(OP_RX_BYTE, FIRST_HEADER_RESET, 8'h00);
        send_item(OP_RX_BYTE, SECOND_HEADER_RESET, 8'h00);
        send_item(OP_RX_BYTE, 8'hA5, 8'h00);
        send_item(OP_RX_BYTE, 8'h01, 8'h00);
        send_item(OP_RX_BYTE, 8'h07, 8'h00);

        // Random phases, each under its own header pair. Reprogram only
        // after every predicted status has come back.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            case (p)
                0: begin hf = 8'h00; hs = 8'hFF; end
                1: begin hf = 8'hFF; hs = 8'h00; end
                2: begin hf = 8'($urandom_range(255)); hs = 8'($urandom_range(255)); end
                3: begin hf = 8'($urandom_range(255)); hs = hf; end
                4: begin hf = 8'($urandom_range(255)); hs = 8'($urandom_range(255)); end
                default: begin hf = FIRST_HEADER_RESET; hs = SECOND_HEADER_RESET; end
            endcase
            write_reg(CFG_FIRST_HEADER, hf);
            write_reg(CFG_SECOND_HEADER, hs);
            hdr_first_now  = hf;
            hdr_second_now = hs;
            calm = (p == 2);
            quota = items_sent + PHASE_ITEMS;
            if (p == 1)
                send_frame(255, 1'b0);
            run_random(quota);
        end
        calm = 1'b0;

        // Wait out the pipeline so late or spurious results still get caught.
        drain_results();
        repeat (8) @(posedge clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
